/* hdl/dpd_pkg.sv */
// Shared constants for the detection proposal decoder.
package dpd_pkg;

    // Largest number of class scores in one row
    localparam int MAX_CLASSES = 128;

    // Row position counter covers five box slots plus the class scores
    localparam int POS_W = ($clog2(MAX_CLASSES + 5) > 8) ? $clog2(MAX_CLASSES + 5) : 8;

    localparam int VALUE_W   = 32;
    localparam int LABEL_W   = 7;
    localparam int CONF_W    = 16;
    localparam int CNT_W     = 8;
    localparam int SIZE_W    = 13;
    localparam int THR_W     = 16;
    localparam int FRAC_W    = 15;
    localparam int PROD_W    = 2 * VALUE_W;
    localparam int EDGE_W    = VALUE_W + 2;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 152;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_CLASS_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_SIZE  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_OBJ_THR     = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCORE_THR   = 2'd3;

    localparam logic [CNT_W-1:0]  RST_CLASS_COUNT = 8'd80;
    localparam logic [SIZE_W-1:0] RST_IMAGE_SIZE  = 13'd320;
    localparam logic [THR_W-1:0]  RST_OBJ_THR     = 16'd16384;
    localparam logic [THR_W-1:0]  RST_SCORE_THR   = 16'd16384;

    // Slots within a row
    localparam logic [POS_W-1:0] POS_CX          = POS_W'(0);
    localparam logic [POS_W-1:0] POS_CY          = POS_W'(1);
    localparam logic [POS_W-1:0] POS_W_BOX       = POS_W'(2);
    localparam logic [POS_W-1:0] POS_H_BOX       = POS_W'(3);
    localparam logic [POS_W-1:0] POS_OBJ         = POS_W'(4);
    localparam logic [POS_W-1:0] POS_FIRST_SCORE = POS_W'(5);

endpackage

/* hdl/detection_proposal_decode.sv */
// Detection proposal decoder: streams detector rows in, emits thresholded boxes.
//
// Input stream (s_axis): one signed Q16.15 value per word, rows laid out as
// cx, cy, w, h, objectness, then class_count class scores. Rows follow each
// other with no gap and no framing; the row position counter finds the end.
// Output stream (m_axis): one word per kept box, carrying left/top/right/bottom
// edges (Q16.15), confidence (Q1.15) and class label.
// Configuration (i_cfg_*): one register written per cycle; the user must write only
// while the block idles, the block itself does not enforce it. Throughput: one input
// word per cycle while s_axis_tready is high. The class argmax updates as each score
// arrives; at a row end the row is captured in stage A, stage B forms the 32x32
// product, the objectness test and the edges, and the output register takes the
// score compare and the confidence saturation; m_axis is driven from the output
// register.
// Stalls: stage A, stage B and the output register absorb backpressure; stage B
// drops a box that fails the objectness test. s_axis_tready drops only while
// all three hold work and m_axis is stalled.
// Reset (synchronous, active low) clears the row position, the pipeline valid
// bits and loads the default configuration.
module detection_proposal_decode (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [dpd_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [dpd_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [dpd_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // [31:0] row_value
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [31:0] left_edge, [63:32] top_edge, [95:64] right_edge,
    // [127:96] bottom_edge, [143:128] confidence, [150:144] class_label, [151] zero
    output logic [dpd_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

    localparam int VW = dpd_pkg::VALUE_W;
    localparam int EW = dpd_pkg::EDGE_W;
    localparam int PW = dpd_pkg::POS_W;
    localparam int LW = dpd_pkg::LABEL_W;

    // ---------------- configuration ----------------
    logic [dpd_pkg::CNT_W-1:0]  r_class_count;
    logic [dpd_pkg::SIZE_W-1:0] r_image_size;
    logic [dpd_pkg::THR_W-1:0]  r_obj_thr;
    logic [dpd_pkg::THR_W-1:0]  r_score_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_class_count <= dpd_pkg::RST_CLASS_COUNT;
            r_image_size  <= dpd_pkg::RST_IMAGE_SIZE;
            r_obj_thr     <= dpd_pkg::RST_OBJ_THR;
            r_score_thr   <= dpd_pkg::RST_SCORE_THR;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                dpd_pkg::CFG_CLASS_COUNT: r_class_count <= i_cfg_data[dpd_pkg::CNT_W-1:0];
                dpd_pkg::CFG_IMAGE_SIZE:  r_image_size  <= i_cfg_data[dpd_pkg::SIZE_W-1:0];
                dpd_pkg::CFG_OBJ_THR:     r_obj_thr     <= i_cfg_data[dpd_pkg::THR_W-1:0];
                dpd_pkg::CFG_SCORE_THR:   r_score_thr   <= i_cfg_data[dpd_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    // class count limited to 1..MAX_CLASSES
    logic [PW-1:0] class_eff;
    logic [PW-1:0] row_last;

    always_comb begin
        if (r_class_count == '0) begin
            class_eff = PW'(1);
        end else if (PW'(r_class_count) > PW'(dpd_pkg::MAX_CLASSES)) begin
            class_eff = PW'(dpd_pkg::MAX_CLASSES);
        end else begin
            class_eff = PW'(r_class_count);
        end
        row_last = dpd_pkg::POS_OBJ + class_eff;
    end

    // ---------------- row accumulation ----------------
    logic                 r_a_valid, r_b_valid, r_o_valid;
    logic                 r_b_pass;
    logic                 b_adv, a_adv;
    logic                 acc, row_end;
    logic signed [VW-1:0] in_val;

    logic [PW-1:0]        r_pos;
    logic signed [VW-1:0] r_cx, r_cy, r_w, r_h, r_obj, r_best;
    logic [LW-1:0]        r_label;
    logic signed [VW-1:0] n_best;
    logic [LW-1:0]        n_label;

    // input waits only while stage A holds a row that cannot move on
    assign s_axis_tready = a_adv;
    assign acc           = s_axis_tvalid && s_axis_tready;
    assign in_val        = $signed(s_axis_tdata[VW-1:0]);
    assign row_end       = (r_pos >= row_last);

    always_comb begin
        n_best  = r_best;
        n_label = r_label;
        if (r_pos == dpd_pkg::POS_FIRST_SCORE) begin
            n_best  = in_val;
            n_label = '0;
        end else if (in_val > r_best) begin
            n_best  = in_val;
            n_label = LW'(r_pos - dpd_pkg::POS_FIRST_SCORE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (acc) begin
            r_pos <= row_end ? '0 : r_pos + PW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            case (r_pos)
                dpd_pkg::POS_CX:    r_cx  <= in_val;
                dpd_pkg::POS_CY:    r_cy  <= in_val;
                dpd_pkg::POS_W_BOX: r_w   <= in_val;
                dpd_pkg::POS_H_BOX: r_h   <= in_val;
                dpd_pkg::POS_OBJ:   r_obj <= in_val;
                default: begin
                    r_best  <= n_best;
                    r_label <= n_label;
                end
            endcase
        end
    end

    // ---------------- stage A: captured row ----------------
    logic signed [VW-1:0] r_a_cx, r_a_cy, r_a_w, r_a_h, r_a_obj, r_a_best;
    logic [LW-1:0]        r_a_label;

    // stage B can always drop a box that fails the objectness test
    assign b_adv = !r_b_valid || !r_b_pass || !r_o_valid || m_axis_tready;
    assign a_adv = !r_a_valid || b_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= (acc && row_end) || (r_a_valid && !a_adv);
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && row_end) begin
            r_a_cx    <= r_cx;
            r_a_cy    <= r_cy;
            r_a_w     <= r_w;
            r_a_h     <= r_h;
            r_a_obj   <= r_obj;
            r_a_best  <= n_best;
            r_a_label <= n_label;
        end
    end

    // ---------------- stage B: product and edges ----------------
    function automatic logic signed [VW-1:0] lower_edge(
        input logic signed [VW-1:0] c,
        input logic signed [VW-1:0] size
    );
        logic signed [EW-1:0] e;
        logic signed [VW-1:0] half;
        half = size >>> 1;
        e    = EW'(c) - EW'(half);
        if (e < 0) begin
            lower_edge = '0;
        end else if (e > EW'(32'sh7FFF_FFFF)) begin
            lower_edge = 32'sh7FFF_FFFF;
        end else begin
            lower_edge = e[VW-1:0];
        end
    endfunction

    function automatic logic signed [VW-1:0] upper_edge(
        input logic signed [VW-1:0] c,
        input logic signed [VW-1:0] size,
        input logic signed [EW-1:0] limit
    );
        logic signed [EW-1:0] e;
        logic signed [VW-1:0] half;
        half = size >>> 1;
        e    = EW'(c) + EW'(half);
        if (e > limit) begin
            e = limit;
        end
        if (e < EW'(32'sh8000_0000)) begin
            upper_edge = 32'sh8000_0000;
        end else begin
            upper_edge = e[VW-1:0];
        end
    endfunction

    logic signed [EW-1:0]  edge_limit;
    assign edge_limit = (EW'($signed({1'b0, r_image_size})) - EW'(1)) <<< dpd_pkg::FRAC_W;

    logic signed [dpd_pkg::PROD_W-1:0] r_b_prod;
    logic signed [VW-1:0]              r_b_left, r_b_top, r_b_right, r_b_bottom;
    logic [LW-1:0]                     r_b_label;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_adv) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_adv && r_a_valid) begin
            r_b_prod   <= r_a_obj * r_a_best;
            r_b_pass   <= (r_a_obj >= $signed({{(VW-dpd_pkg::THR_W){1'b0}}, r_obj_thr}));
            r_b_left   <= lower_edge(r_a_cx, r_a_w);
            r_b_top    <= lower_edge(r_a_cy, r_a_h);
            r_b_right  <= upper_edge(r_a_cx, r_a_w, edge_limit);
            r_b_bottom <= upper_edge(r_a_cy, r_a_h, edge_limit);
            r_b_label  <= r_a_label;
        end
    end

    // ---------------- output register ----------------
    logic                     prod_ok;
    logic [dpd_pkg::CONF_W-1:0] conf;
    logic                     o_load;
    logic [dpd_pkg::OUT_DATA_W-1:0] r_o_data;

    assign prod_ok = (r_b_prod >= $signed({{(dpd_pkg::PROD_W - dpd_pkg::THR_W
                                             - dpd_pkg::FRAC_W){1'b0}},
                                           r_score_thr, {dpd_pkg::FRAC_W{1'b0}}}));
    // product is non-negative whenever it passes the score test
    assign conf    = (|r_b_prod[dpd_pkg::PROD_W-2:VW-1]) ? '1
                   : r_b_prod[VW-2:dpd_pkg::FRAC_W];
    assign o_load  = !r_o_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (o_load) begin
            r_o_valid <= r_b_valid && r_b_pass && prod_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_load && r_b_valid) begin
            r_o_data <= {1'b0, r_b_label, conf, r_b_bottom, r_b_right, r_b_top, r_b_left};
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_data;

endmodule

/* hdl/dpd_checker.sv */
// Port-level checks for the detection proposal decoder, bound to the top level.
module dpd_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               s_axis_tvalid,
    input logic                               s_axis_tready,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [dpd_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

    // no box comes out of reset
    a_rst_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("output word valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output word changed");

    // lower edges are clamped at zero
    a_left_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !m_axis_tdata[31] && !m_axis_tdata[63])
        else $error("left or top edge negative");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !m_axis_tdata[151])
        else $error("padding bit set");

    // input is only held off while the output side is stalled
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output backpressure");

endmodule

bind detection_proposal_decode dpd_checker u_dpd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* bench/dpd_checker.sv */
// Checker for the detection proposal decoder: predicts boxes from accepted row words and compares.
module dpd_scoreboard (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [dpd_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [dpd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    input  logic [dpd_pkg::IN_DATA_W-1:0]   i_s_tdata,
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    input  logic [dpd_pkg::OUT_DATA_W-1:0]  i_m_tdata,
    output int                              o_pending,
    output int                              o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     VW       = dpd_pkg::VALUE_W;
    localparam longint INT32_HI = 2147483647;
    localparam longint INT32_LO = -INT32_HI - 1;
    localparam longint ONE_Q    = 64'sd1 << dpd_pkg::FRAC_W;

    typedef struct {
        logic [VW-1:0]                left_edge;
        logic [VW-1:0]                top_edge;
        logic [VW-1:0]                right_edge;
        logic [VW-1:0]                bottom_edge;
        logic [dpd_pkg::CONF_W-1:0]  confidence;
        logic [dpd_pkg::LABEL_W-1:0] class_label;
    } t_box;

    t_box box_q[$];
    int   fail_n = 0;

    // Shadow configuration
    logic [dpd_pkg::CNT_W-1:0]  class_count_q;
    logic [dpd_pkg::SIZE_W-1:0] image_size_q;
    logic [dpd_pkg::THR_W-1:0]  obj_thr_q;
    logic [dpd_pkg::THR_W-1:0]  score_thr_q;

    // Row state
    logic [dpd_pkg::POS_W-1:0]   pos_q;
    logic signed [VW-1:0]        cx_q, cy_q, w_q, h_q, obj_q, best_q;
    logic [dpd_pkg::LABEL_W-1:0] label_q;

    function automatic logic [VW-1:0] clip32(input longint e);
        if (e > INT32_HI) return INT32_HI[VW-1:0];
        if (e < INT32_LO) return INT32_LO[VW-1:0];
        return e[VW-1:0];
    endfunction

    // floor(size/2): arithmetic shift keeps odd negatives rounding down
    function automatic longint half_size(input logic signed [VW-1:0] s);
        return longint'(s >>> 1);
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            fail_n++;
            if (fail_n <= 10)
                $display("%t: %s mismatch: expected %h, got %h", $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge i_clk) begin
        int                             last;
        longint                         prod, limit, conf, edge_v;
        logic signed [VW-1:0]           v;
        logic [dpd_pkg::OUT_DATA_W-1:0] d;
        t_box                           bx;
        if (!i_rst_n) begin
            class_count_q = dpd_pkg::RST_CLASS_COUNT;
            image_size_q  = dpd_pkg::RST_IMAGE_SIZE;
            obj_thr_q     = dpd_pkg::RST_OBJ_THR;
            score_thr_q   = dpd_pkg::RST_SCORE_THR;
            pos_q   = '0;
            cx_q    = '0;
            cy_q    = '0;
            w_q     = '0;
            h_q     = '0;
            obj_q   = '0;
            best_q  = '0;
            label_q = '0;
            box_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    dpd_pkg::CFG_CLASS_COUNT: class_count_q = i_cfg_data[dpd_pkg::CNT_W-1:0];
                    dpd_pkg::CFG_IMAGE_SIZE:  image_size_q  = i_cfg_data[dpd_pkg::SIZE_W-1:0];
                    dpd_pkg::CFG_OBJ_THR:     obj_thr_q     = i_cfg_data[dpd_pkg::THR_W-1:0];
                    dpd_pkg::CFG_SCORE_THR:   score_thr_q   = i_cfg_data[dpd_pkg::THR_W-1:0];
                    default: ;
                endcase
            end

            if (i_s_tvalid && i_s_tready) begin
                v = i_s_tdata;
                last = 4 + ((class_count_q == 0) ? 1 :
                            (class_count_q > dpd_pkg::MAX_CLASSES) ? dpd_pkg::MAX_CLASSES :
                            int'(class_count_q));
                case (pos_q)
                    dpd_pkg::POS_CX:    cx_q  = v;
                    dpd_pkg::POS_CY:    cy_q  = v;
                    dpd_pkg::POS_W_BOX: w_q   = v;
                    dpd_pkg::POS_H_BOX: h_q   = v;
                    dpd_pkg::POS_OBJ:   obj_q = v;
                    dpd_pkg::POS_FIRST_SCORE: begin
                        best_q  = v;
                        label_q = '0;
                    end
                    default: begin
                        // strict compare: first maximum keeps the label
                        if (v > best_q) begin
                            best_q  = v;
                            label_q = dpd_pkg::LABEL_W'(pos_q - dpd_pkg::POS_FIRST_SCORE);
                        end
                    end
                endcase

                if (int'(pos_q) < last) begin
                    pos_q++;
                end else begin
                    pos_q = '0;
                    prod  = longint'(obj_q) * longint'(best_q);
                    limit = (longint'(image_size_q) - 1) * ONE_Q;
                    if (longint'(obj_q) >= longint'(obj_thr_q) &&
                        prod >= longint'(score_thr_q) * ONE_Q) begin
                        edge_v = longint'(cx_q) - half_size(w_q);
                        bx.left_edge = clip32(edge_v < 0 ? 0 : edge_v);
                        edge_v = longint'(cy_q) - half_size(h_q);
                        bx.top_edge = clip32(edge_v < 0 ? 0 : edge_v);
                        edge_v = longint'(cx_q) + half_size(w_q);
                        bx.right_edge = clip32(edge_v > limit ? limit : edge_v);
                        edge_v = longint'(cy_q) + half_size(h_q);
                        bx.bottom_edge = clip32(edge_v > limit ? limit : edge_v);
                        conf = prod / ONE_Q;
                        if (conf > 65535) conf = 65535;
                        if (conf < 0) conf = 0;
                        bx.confidence  = conf[dpd_pkg::CONF_W-1:0];
                        bx.class_label = label_q;
                        box_q.insert(box_q.size(), bx);
                    end
                end
            end

            if (i_m_tvalid && i_m_tready) begin
                d = i_m_tdata;
                if (box_q.size() == 0) begin
                    fail_n++;
                    if (fail_n <= 10)
                        $display("%t: box word with nothing expected: %h", $time, d);
                end else begin
                    bx = box_q.pop_front();
                    check_field("left_edge", bx.left_edge, d[31:0]);
                    check_field("top_edge", bx.top_edge, d[63:32]);
                    check_field("right_edge", bx.right_edge, d[95:64]);
                    check_field("bottom_edge", bx.bottom_edge, d[127:96]);
                    check_field("confidence", 32'(bx.confidence), 32'(d[143:128]));
                    check_field("class_label", 32'(bx.class_label), 32'(d[150:144]));
                    check_field("pad bit", 32'd0, 32'(d[151]));
                end
            end
        end
        o_pending    = box_q.size();
        o_fail_count = fail_n;
    end

endmodule

/* bench/testbench.sv */
// Top of the decoder bench: clock, reset, row stimulus, output backpressure and the verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TOTAL_ITEMS = 1050;
    localparam int IDLE_SETTLE = 8;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 2000;
    localparam int MAXC        = dpd_pkg::MAX_CLASSES;

    typedef enum {ROW_GOOD, ROW_PLAIN, ROW_NOISE} t_row_kind;

    logic                            i_clk   = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            cfg_we  = 1'b0;
    logic [dpd_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [dpd_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [dpd_pkg::IN_DATA_W-1:0]   s_axis_tdata = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [dpd_pkg::OUT_DATA_W-1:0]  m_axis_tdata;

    int pending;
    int fail_count;
    int items_sent  = 0;
    int idle_cycles = 0;
    int calm_words  = 0;
    bit hold_req    = 1'b0;

    // Mirror of the row counter and the settings in force, for shaping rows
    int row_pos   = 0;
    int cur_count = 80;
    int img_size  = 320;
    int obj_thr   = 16384;
    int score_thr = 16384;

    detection_proposal_decode u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    dpd_scoreboard u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always #5 i_clk = ~i_clk;

    // Watchdog on handshake activity
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL detection_proposal_decode");
            $finish;
        end
    end

    // Receiver: random ready/stall segments, one long hold-off on request
    initial begin
        int  seg_left;
        int  hold_left;
        int  r;
        bit  ready_now;
        bit  hold_done;
        seg_left  = 0;
        hold_left = 0;
        ready_now = 1'b0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                if (seg_left == 0) begin
                    r = $urandom_range(0, 99);
                    if (!ready_now || r < 40) begin
                        ready_now = 1'b1;
                        r = $urandom_range(0, 99);
                        seg_left = (r < 10) ? $urandom_range(40, 200) : $urandom_range(1, 8);
                    end else begin
                        ready_now = 1'b0;
                        r = $urandom_range(0, 99);
                        if (r < 70)      seg_left = $urandom_range(1, 3);
                        else if (r < 94) seg_left = $urandom_range(4, 12);
                        else             seg_left = $urandom_range(20, 60);
                    end
                end
                seg_left--;
                m_axis_tready <= ready_now;
            end
        end
    end

    function automatic int sender_gap();
        int r;
        if (calm_words > 0) begin
            calm_words--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm_words = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_word(input logic [31:0] v);
        int gap;
        gap = sender_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
        if (row_pos >= 4 + cur_count) row_pos = 0;
        else row_pos++;
    endtask

    task automatic send_box_row(input logic [31:0] cx, cy, w, h, obj, score);
        send_word(cx);
        send_word(cy);
        send_word(w);
        send_word(h);
        send_word(obj);
        send_word(score);
    endtask

    task automatic cfg_write(input logic [dpd_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [dpd_pkg::CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Wait until every expected box is out, plus a margin for row ends with no box
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (IDLE_SETTLE) @(posedge i_clk);
    endtask

    // Upper data bits are junk on the narrow registers
    task automatic apply_settings(input int cnt, input int img, input int othr, input int sthr);
        int c;
        cfg_write(dpd_pkg::CFG_CLASS_COUNT, {8'($urandom), 8'(cnt)});
        cfg_write(dpd_pkg::CFG_IMAGE_SIZE, {3'($urandom), 13'(img)});
        cfg_write(dpd_pkg::CFG_OBJ_THR, 16'(othr));
        cfg_write(dpd_pkg::CFG_SCORE_THR, 16'(sthr));
        c = cnt & 255;
        cur_count = (c == 0) ? 1 : (c > MAXC) ? MAXC : c;
        img_size  = img & 8191;
        obj_thr   = othr & 65535;
        score_thr = sthr & 65535;
    endtask

    task automatic finish_row();
        while (row_pos != 0) send_word($urandom_range(0, 40000));
    endtask

    task automatic send_row(input t_row_kind kind);
        int     vals [0:MAXC+4];
        int     span;
        int     pick;
        longint need;
        longint top_score;
        span = ((img_size == 0) ? 1 : img_size) * 32768;
        case (kind)
            ROW_GOOD: begin
                vals[0] = $urandom_range(0, span);
                vals[1] = $urandom_range(0, span);
                vals[2] = $urandom_range(0, span / 2);
                vals[3] = $urandom_range(0, span / 2);
                if ($urandom_range(0, 7) == 0) vals[2] = -vals[2] - 1;
                if ($urandom_range(0, 7) == 0) vals[3] = -vals[3] - 1;
                vals[4] = obj_thr + $urandom_range(0, 40000);
                if (vals[4] == 0) vals[4] = 1;
                // smallest best score that still clears the score threshold
                need = (longint'(score_thr) * 32768 + vals[4] - 1) / vals[4];
                top_score = need + $urandom_range(0, 30000);
                if (top_score > 64'sd2147483647) top_score = 64'sd2147483647;
                pick = $urandom_range(0, cur_count - 1);
                for (int i = 0; i < cur_count; i++)
                    vals[5+i] = (i == pick || $urandom_range(0, 5) == 0) ?
                                int'(top_score) : int'($urandom_range(0, 32'(top_score)));
            end
            ROW_PLAIN: begin
                for (int i = 0; i < 4; i++) vals[i] = $urandom_range(0, span);
                for (int i = 4; i <= 4 + cur_count; i++)
                    vals[i] = int'($urandom_range(0, 48000)) - 8000;
            end
            default: begin
                for (int i = 0; i <= 4 + cur_count; i++) vals[i] = $urandom;
            end
        endcase
        for (int i = 0; i <= 4 + cur_count; i++) send_word(vals[i]);
    endtask

    initial begin
        int phase;
        int quota;
        int start;
        int cnt, img, othr, sthr;
        int r;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: one score per row (count 0 acts as 1), image size 0
        apply_settings(0, 0, 0, 0);
        // saturating edges, odd negative width, clamp to -1 pixel
        send_box_row(32'h7FFF_FFFF, 32'h8000_0000, -3, 32'h8000_0000, 32767, 32768);
        // confidence saturates
        send_box_row(0, -1, 5, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        settle();
        apply_settings(0, 4096, 1000, 2000);
        // both thresholds met exactly
        send_box_row(100 << 15, 4095 << 15, 7, 8191 << 15, 1000, 65536);
        // objectness one short, then score one short of the product threshold: no box
        send_box_row(200 << 15, 10 << 15, 8, 9, 999, 70000);
        send_box_row(300 << 15, 20 << 15, 6, 3, 1000, 65535);
        settle();

        // Backpressure: every row makes a box while the receiver holds off
        apply_settings(1, 320, 0, 0);
        hold_req <= 1'b1;
        repeat (40) send_row(ROW_GOOD);

        phase = 0;
        while (items_sent < TOTAL_ITEMS) begin
            settle();
            case (phase)
                0: begin
                    cnt = 128; img = 1; othr = 32768; sthr = 32768;
                end
                1: begin
                    cnt = 255; img = 8191; othr = 65535; sthr = 65535;
                end
                default: begin
                    r = $urandom_range(0, 99);
                    if (r < 40)      cnt = $urandom_range(1, 4);
                    else if (r < 65) cnt = $urandom_range(5, 16);
                    else if (r < 75) cnt = 80;
                    else if (r < 83) cnt = 128;
                    else if (r < 90) cnt = 255;
                    else if (r < 95) cnt = 0;
                    else             cnt = $urandom_range(17, 127);
                    r = $urandom_range(0, 9);
                    img = (r == 0) ? 0 : (r == 1) ? 1 : (r == 2) ? 4096 : $urandom_range(1, 4096);
                    r = $urandom_range(0, 19);
                    othr = (r < 3) ? 0 : (r < 5) ? 32768 : $urandom_range(0, 32768);
                    r = $urandom_range(0, 19);
                    sthr = (r < 3) ? 0 : (r < 5) ? 32768 : $urandom_range(0, 32768);
                end
            endcase
            apply_settings(cnt, img, othr, sthr);
            // a row left open by the last phase ends under the new class count
            finish_row();
            quota = $urandom_range(40, 150);
            if (quota > TOTAL_ITEMS - items_sent) quota = TOTAL_ITEMS - items_sent;
            start = items_sent;
            while (items_sent - start < quota) begin
                r = $urandom_range(0, 9);
                send_row((r < 5) ? ROW_GOOD : (r < 8) ? ROW_PLAIN : ROW_NOISE);
            end
            if ($urandom_range(0, 2) == 0)
                repeat ($urandom_range(1, 4 + cur_count)) send_word($urandom);
            phase++;
        end

        settle();
        if (fail_count == 0 && pending == 0)
            $display("PASS detection_proposal_decode");
        else
            $display("FAIL detection_proposal_decode");
        $finish;
    end

endmodule
